[rtl/core/pfe_pkg.sv]
// Shared types and constants for the protobuf field encoder.
`default_nettype none

package pfe_pkg;

  // Function codes of an input request
  localparam logic [1:0] FN_UINT = 2'd0;
  localparam logic [1:0] FN_SINT = 2'd1;
  localparam logic [1:0] FN_HDR  = 2'd2;
  localparam logic [1:0] FN_PAY  = 2'd3;

  // Wire types placed in the low tag bits
  localparam int         TAG_SHIFT   = 3;
  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_LEN    = 3'd2;

  // LEB128 layout
  localparam logic [7:0] CONT_BIT   = 8'h80;
  localparam int         GROUP_BITS = 7;

  localparam int FIELD_W   = 29;
  localparam int VALUE_W   = 64;
  localparam int MAX_LEN_W = 16;
  localparam int TAG_W     = FIELD_W + TAG_SHIFT;

  localparam int LENGTH_BITS_DEF = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAG,
    ST_VAL,
    ST_RAW
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // take the input request
    logic emit;     // load the output register
    logic raw;      // emit the low byte as is, no varint framing
    logic last;     // final byte of the request
    logic advance;  // tag done, move the value varint into the shifter
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip;      // request produces no bytes
    logic pay;       // request is a payload byte
    logic more;      // current varint has further groups after this byte
    logic out_free;  // output register can take a byte this cycle
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/pfe_ctrl.sv]
// Sequencing state machine of the protobuf field encoder.
`default_nettype none

module pfe_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pfe_pkg::sts_t sts,
  output pfe_pkg::cmd_t      cmd
);

  pfe_pkg::state_t state;
  pfe_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state)
      pfe_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && !sts.skip) begin
          state_next = sts.pay ? pfe_pkg::ST_RAW : pfe_pkg::ST_TAG;
        end
      end
      pfe_pkg::ST_TAG: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (!sts.more) begin
            cmd.advance = 1'b1;
            state_next  = pfe_pkg::ST_VAL;
          end
        end
      end
      pfe_pkg::ST_VAL: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = !sts.more;
          if (!sts.more) begin
            state_next = pfe_pkg::ST_IDLE;
          end
        end
      end
      pfe_pkg::ST_RAW: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.raw    = 1'b1;
          cmd.last   = 1'b1;
          state_next = pfe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pfe_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.last |=> state == pfe_pkg::ST_IDLE)
    else $error("last byte emitted but controller did not return to idle");

  a_work_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && !sts.skip |=> state != pfe_pkg::ST_IDLE)
    else $error("accepted request with output did not start emitting");
`endif

endmodule

`default_nettype wire

[rtl/core/pfe_datapath.sv]
// Varint shifter, length clipping, payload budget and output register.
`default_nettype none

module pfe_datapath #(
  parameter int LENGTH_BITS = pfe_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [1:0]                    func,
  input  wire logic [pfe_pkg::FIELD_W-1:0]   field_number,
  input  wire logic [pfe_pkg::VALUE_W-1:0]   value,
  input  wire logic [pfe_pkg::MAX_LEN_W-1:0] max_length,
  input  wire logic                          always_emit,
  input  wire logic [7:0]                    data_byte,
  input  wire pfe_pkg::cmd_t                 cmd,
  output pfe_pkg::sts_t                      sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_byte,
  output logic                               last
);

  // Clipped length never exceeds max_length, so the budget needs at most
  // MAX_LEN_W bits, fewer when LENGTH_BITS saturates it harder.
  localparam int BudgetW = (LENGTH_BITS < pfe_pkg::MAX_LEN_W) ? LENGTH_BITS
                                                              : pfe_pkg::MAX_LEN_W;
  localparam logic [pfe_pkg::MAX_LEN_W-1:0] LenLim =
    pfe_pkg::MAX_LEN_W'((17'd1 << BudgetW) - 17'd1);

  logic [pfe_pkg::VALUE_W-1:0]   sh;
  logic [pfe_pkg::VALUE_W-1:0]   val;
  logic [BudgetW-1:0]            budget;

  logic [pfe_pkg::VALUE_W-1:0]   zz;
  logic [pfe_pkg::VALUE_W-1:0]   vv;
  logic [pfe_pkg::MAX_LEN_W-1:0] len_min;
  logic [BudgetW-1:0]            len;
  logic [pfe_pkg::TAG_W-1:0]     tag;
  logic                          is_hdr;
  logic                          is_pay;
  logic [7:0]                    byte_next;

  assign is_hdr = (func == pfe_pkg::FN_HDR);
  assign is_pay = (func == pfe_pkg::FN_PAY);

  always_comb begin
    zz = {value[pfe_pkg::VALUE_W-2:0], 1'b0} ^ {pfe_pkg::VALUE_W{value[pfe_pkg::VALUE_W-1]}};
    vv = (func == pfe_pkg::FN_SINT) ? zz : value;

    if (value[pfe_pkg::VALUE_W-1:pfe_pkg::MAX_LEN_W] != '0) begin
      len_min = max_length;
    end else if (value[pfe_pkg::MAX_LEN_W-1:0] < max_length) begin
      len_min = value[pfe_pkg::MAX_LEN_W-1:0];
    end else begin
      len_min = max_length;
    end
    len = (len_min > LenLim) ? BudgetW'(LenLim) : BudgetW'(len_min);

    tag = {field_number, is_hdr ? pfe_pkg::WIRE_LEN : pfe_pkg::WIRE_VARINT};

    case (func)
      pfe_pkg::FN_UINT: sts.skip = (vv == '0);
      pfe_pkg::FN_SINT: sts.skip = (vv == '0);
      pfe_pkg::FN_HDR:  sts.skip = (value == '0) && !always_emit;
      pfe_pkg::FN_PAY:  sts.skip = (budget == '0);
      default:          sts.skip = 1'b1;
    endcase
    sts.pay      = is_pay;
    sts.more     = (sh[pfe_pkg::VALUE_W-1:pfe_pkg::GROUP_BITS] != '0);
    sts.out_free = !out_valid || out_ready;

    if (cmd.raw) begin
      byte_next = sh[7:0];
    end else begin
      byte_next = {1'b0, sh[6:0]} | (sts.more ? pfe_pkg::CONT_BIT : 8'h00);
    end
  end

  // Shifter and pending value
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sh  <= is_pay ? pfe_pkg::VALUE_W'(data_byte) : pfe_pkg::VALUE_W'(tag);
      val <= is_hdr ? pfe_pkg::VALUE_W'(len) : vv;
    end else if (cmd.emit && !cmd.raw) begin
      sh <= cmd.advance ? val : (sh >> pfe_pkg::GROUP_BITS);
    end
  end

  // Payload budget: load on every header, count down on each passed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= '0;
    end else if (cmd.accept && is_hdr) begin
      budget <= len;
    end else if (cmd.accept && is_pay && (budget != '0)) begin
      budget <= budget - BudgetW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= byte_next;
      last     <= cmd.last;
    end
  end

`ifndef SYNTHESIS
  a_budget_no_rise: assert property (@(posedge clk) disable iff (rst)
    !(cmd.accept && is_hdr) |=> budget <= $past(budget))
    else $error("payload budget grew without a header");

  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("byte emitted into an occupied output register");
`endif

endmodule

`default_nettype wire

[rtl/core/protobuf_field_encoder.sv]
// Top level of the protobuf field encoder: controller plus datapath.
//
//   Channel  Handshake            Payload
//   -------  -------------------  ----------------------------------------------
//   input    in_valid / in_ready  func, field_number, value, max_length,
//                                 always_emit, data_byte
//   output   out_valid/out_ready  out_byte, last
//
// Each request is accepted while idle, then one byte is emitted per cycle while the
// output is free: tag bytes (1..5) plus value bytes (1..10) for a field, one raw
// byte for a payload byte, none for a skipped request. The shifter moves 7 bits a byte.
// The registered output lets the next request be accepted while the final byte
// still waits downstream. A stalled output holds the shifter in place.
// Reset (synchronous) returns the controller to idle, empties the output
// register and clears the payload budget.
`default_nettype none

module protobuf_field_encoder #(
  parameter int LENGTH_BITS = pfe_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    func,
  input  wire logic [pfe_pkg::FIELD_W-1:0]   field_number,
  input  wire logic [pfe_pkg::VALUE_W-1:0]   value,
  input  wire logic [pfe_pkg::MAX_LEN_W-1:0] max_length,
  input  wire logic                          always_emit,
  input  wire logic [7:0]                    data_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_byte,
  output logic                               last
);

  pfe_pkg::cmd_t cmd;
  pfe_pkg::sts_t sts;

  // Sequence tag, value and raw bytes; accept only when idle
  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the varint shifter, length clip, budget and output register
  pfe_datapath #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .func         (func),
    .field_number (field_number),
    .value        (value),
    .max_length   (max_length),
    .always_emit  (always_emit),
    .data_byte    (data_byte),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last         (last)
  );

endmodule

`default_nettype wire
